[rtl/core/sms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types, constants and helpers of the sigma-clipped median stack.
// ----------------------------------------------------------------------------
package sms_pkg;

   // fixed geometry of one word
   localparam int NumInputs = 8;
   localparam int SampleW   = 16;
   localparam int CountW    = 4;
   localparam int CsrDataW  = 4;
   localparam int CsrIndexW = 8;

   // widths of the exact moment arithmetic
   localparam int SumW  = SampleW + 3;      // sum of samples
   localparam int SqW   = 2 * SampleW;      // one square
   localparam int QW    = SqW + 3;          // sum of squares
   localparam int NvW   = SampleW + CountW; // n * v
   localparam int VarW  = QW + CountW;      // n*Q - S^2
   localparam int D2W   = 2 * NvW;          // (n*v - S)^2
   localparam int K2W   = 2 * CsrDataW;     // k^2
   localparam int LimW  = VarW + K2W;       // k^2 * var

   // configuration register indexes
   localparam logic [CsrIndexW-1:0] CsrClipK       = CsrIndexW'(0);
   localparam logic [CsrIndexW-1:0] CsrClipMinCount = CsrIndexW'(1);

   // reset values of the registers
   localparam logic [CsrDataW-1:0] ClipKReset        = CsrDataW'(2);
   localparam logic [CsrDataW-1:0] ClipMinCountReset = CsrDataW'(3);

   typedef logic [SampleW-1:0]   sample_type;
   typedef sample_type [NumInputs-1:0] sample_vec_type;
   typedef logic [NumInputs-1:0] lane_mask_type;
   typedef logic [CountW-1:0]    count_type;

   // word handed from the statistics pipe to the selection pipe
   typedef struct packed {
      sample_vec_type                  vals;
      lane_mask_type                   mask;
      logic                            clip;
      logic [LimW-1:0]                 lim;
      logic [NumInputs-1:0][D2W-1:0]   d2;
   } stat_type;

   // number of set bits in a lane mask
   function automatic count_type count_ones(input lane_mask_type bits);
      count_type cnt;
      cnt = '0;
      for (int i = 0; i < NumInputs; i++) begin
         cnt = cnt + count_type'(bits[i]);
      end
      return cnt;
   endfunction

endpackage

[rtl/core/sms_stats.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_stats
// Five-stage pipe: moments, n*Q and S^2, variance, squared distances and the
// clipping limit k^2 * var for every lane.
// ----------------------------------------------------------------------------
module sms_stats (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sms_pkg::sample_vec_type in_vals,
   input  sms_pkg::lane_mask_type  in_mask,
   input  logic [3:0]              clip_k,
   input  logic [3:0]              clip_min_count,
   output logic                    out_valid,
   input  logic                    out_ready,
   output sms_pkg::stat_type       out_stat
);
   import sms_pkg::*;

   localparam int Stages = 5;

   logic [Stages:1] vld_ff;
   logic [Stages:1] adv;

   // stage 1: masked samples, squares, sum, count
   sample_vec_type                vals1_ff, vals1_in;
   lane_mask_type                 mask1_ff;
   logic [NumInputs-1:0][SqW-1:0] sq1_ff, sq1_in;
   logic [SumW-1:0]               sum1_ff, sum1_in;
   count_type                     n1_ff, n1_in;
   logic                          clip1_ff, clip1_in;
   logic [K2W-1:0]                k2_1_ff, k2_1_in;

   // stage 2: sum of squares, n*v
   sample_vec_type                vals2_ff;
   lane_mask_type                 mask2_ff;
   logic                          clip2_ff;
   logic [K2W-1:0]                k2_2_ff;
   count_type                     n2_ff;
   logic [SumW-1:0]               sum2_ff;
   logic [QW-1:0]                 q2_ff, q2_in;
   logic [NumInputs-1:0][NvW-1:0] nv2_ff, nv2_in;

   // stage 3: n*Q, S^2, |n*v - S|
   sample_vec_type                vals3_ff;
   lane_mask_type                 mask3_ff;
   logic                          clip3_ff;
   logic [K2W-1:0]                k2_3_ff;
   logic [VarW-1:0]               nq3_ff, nq3_in;
   logic [VarW-1:0]               ss3_ff, ss3_in;
   logic [NumInputs-1:0][NvW-1:0] d3_ff, d3_in;

   // stage 4: variance, squared distances
   sample_vec_type                vals4_ff;
   lane_mask_type                 mask4_ff;
   logic                          clip4_ff;
   logic [K2W-1:0]                k2_4_ff;
   logic [VarW-1:0]               var4_ff, var4_in;
   logic [NumInputs-1:0][D2W-1:0] d2_4_ff, d2_4_in;

   // stage 5: limit
   logic [LimW-1:0]               lim5_in;
   stat_type                      stat5_ff;

   // stall chain: a stage loads when empty or when the next one moves
   always_comb begin
      adv[Stages] = !vld_ff[Stages] || out_ready;
      for (int s = Stages - 1; s >= 1; s--) begin
         adv[s] = !vld_ff[s] || adv[s+1];
      end
   end

   assign in_ready  = adv[1];
   assign out_valid = vld_ff[Stages];
   assign out_stat  = stat5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) vld_ff[1] <= in_valid;
         for (int s = 2; s <= Stages; s++) begin
            if (adv[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // stage 1 logic
   always_comb begin
      sum1_in = '0;
      for (int i = 0; i < NumInputs; i++) begin
         vals1_in[i] = in_mask[i] ? in_vals[i] : '0;
         sq1_in[i]   = SqW'(vals1_in[i]) * SqW'(vals1_in[i]);
         sum1_in     = sum1_in + SumW'(vals1_in[i]);
      end
      n1_in    = count_ones(in_mask);
      clip1_in = n1_in > clip_min_count;
      k2_1_in  = K2W'(clip_k) * K2W'(clip_k);
   end

   // stage 2 logic
   always_comb begin
      q2_in = '0;
      for (int i = 0; i < NumInputs; i++) begin
         q2_in     = q2_in + QW'(sq1_ff[i]);
         nv2_in[i] = NvW'(n1_ff) * NvW'(vals1_ff[i]);
      end
   end

   // stage 3 logic
   always_comb begin
      nq3_in = VarW'(n2_ff) * VarW'(q2_ff);
      ss3_in = VarW'(sum2_ff) * VarW'(sum2_ff);
      for (int i = 0; i < NumInputs; i++) begin
         d3_in[i] = (nv2_ff[i] >= NvW'(sum2_ff)) ? nv2_ff[i] - NvW'(sum2_ff)
                                                 : NvW'(sum2_ff) - nv2_ff[i];
      end
   end

   // stage 4 logic
   always_comb begin
      var4_in = nq3_ff - ss3_ff;
      for (int i = 0; i < NumInputs; i++) begin
         d2_4_in[i] = D2W'(d3_ff[i]) * D2W'(d3_ff[i]);
      end
   end

   // stage 5 logic
   assign lim5_in = LimW'(k2_4_ff) * LimW'(var4_ff);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         vals1_ff <= vals1_in;
         mask1_ff <= in_mask;
         sq1_ff   <= sq1_in;
         sum1_ff  <= sum1_in;
         n1_ff    <= n1_in;
         clip1_ff <= clip1_in;
         k2_1_ff  <= k2_1_in;
      end
      if (adv[2]) begin
         vals2_ff <= vals1_ff;
         mask2_ff <= mask1_ff;
         clip2_ff <= clip1_ff;
         k2_2_ff  <= k2_1_ff;
         n2_ff    <= n1_ff;
         sum2_ff  <= sum1_ff;
         q2_ff    <= q2_in;
         nv2_ff   <= nv2_in;
      end
      if (adv[3]) begin
         vals3_ff <= vals2_ff;
         mask3_ff <= mask2_ff;
         clip3_ff <= clip2_ff;
         k2_3_ff  <= k2_2_ff;
         nq3_ff   <= nq3_in;
         ss3_ff   <= ss3_in;
         d3_ff    <= d3_in;
      end
      if (adv[4]) begin
         vals4_ff <= vals3_ff;
         mask4_ff <= mask3_ff;
         clip4_ff <= clip3_ff;
         k2_4_ff  <= k2_3_ff;
         var4_ff  <= var4_in;
         d2_4_ff  <= d2_4_in;
      end
      if (adv[5]) begin
         stat5_ff.vals <= vals4_ff;
         stat5_ff.mask <= mask4_ff;
         stat5_ff.clip <= clip4_ff;
         stat5_ff.lim  <= lim5_in;
         stat5_ff.d2   <= d2_4_ff;
      end
   end

endmodule

[rtl/core/sms_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_select
// Three-stage pipe: keep decision with fallback, pairwise rank compare, and
// selection of the upper median into the output register.
// ----------------------------------------------------------------------------
module sms_select (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sms_pkg::stat_type   in_stat,
   output logic                out_valid,
   input  logic                out_ready,
   output sms_pkg::sample_type out_median,
   output sms_pkg::count_type  out_count
);
   import sms_pkg::*;

   localparam int Stages = 3;

   logic [Stages:1] vld_ff;
   logic [Stages:1] adv;

   // stage 1: kept lanes
   sample_vec_type vals1_ff;
   lane_mask_type  keep1_ff, keep1_in;
   count_type      m1_ff, m1_in;

   // stage 2: lt[i][j] set when kept lane j sorts ahead of lane i
   sample_vec_type                     vals2_ff;
   lane_mask_type                      keep2_ff;
   count_type                          m2_ff;
   logic [NumInputs-1:0][NumInputs-1:0] lt2_ff, lt2_in;

   // stage 3: output register
   sample_type median3_ff, median3_in;
   count_type  m3_ff;

   lane_mask_type clipped;

   always_comb begin
      adv[Stages] = !vld_ff[Stages] || out_ready;
      for (int s = Stages - 1; s >= 1; s--) begin
         adv[s] = !vld_ff[s] || adv[s+1];
      end
   end

   assign in_ready   = adv[1];
   assign out_valid  = vld_ff[Stages];
   assign out_median = median3_ff;
   assign out_count  = m3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) vld_ff[1] <= in_valid;
         for (int s = 2; s <= Stages; s++) begin
            if (adv[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // keep test, falling back to all valid lanes when nothing survives
   always_comb begin
      for (int i = 0; i < NumInputs; i++) begin
         clipped[i] = in_stat.mask[i] && in_stat.clip &&
                      (LimW'(in_stat.d2[i]) <= in_stat.lim);
      end
      if (clipped == '0) begin
         keep1_in = in_stat.mask;
      end else begin
         keep1_in = clipped;
      end
      m1_in = count_ones(keep1_in);
   end

   // pairwise order, lane index breaks ties
   always_comb begin
      for (int i = 0; i < NumInputs; i++) begin
         for (int j = 0; j < NumInputs; j++) begin
            lt2_in[i][j] = keep1_ff[j] &&
                           ((vals1_ff[j] < vals1_ff[i]) ||
                            ((vals1_ff[j] == vals1_ff[i]) && (j < i)));
         end
      end
   end

   // the kept lane whose rank is m/2 is the upper median
   always_comb begin
      median3_in = '0;
      for (int i = 0; i < NumInputs; i++) begin
         if (keep2_ff[i] && (count_ones(lt2_ff[i]) == (m2_ff >> 1))) begin
            median3_in = median3_in | vals2_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         vals1_ff <= in_stat.vals;
         keep1_ff <= keep1_in;
         m1_ff    <= m1_in;
      end
      if (adv[2]) begin
         vals2_ff <= vals1_ff;
         keep2_ff <= keep1_ff;
         m2_ff    <= m1_ff;
         lt2_ff   <= lt2_in;
      end
      if (adv[3]) begin
         median3_ff <= median3_in;
         m3_ff      <= m2_ff;
      end
   end

endmodule

[rtl/core/sigma_clipped_median_stack_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigma_clipped_median_stack_top
// Sigma-clipped upper median of eight co-located image samples per word.
//
//   channel  handshake              payload
//   req      req_valid/req_ready    req_sample_0..7, req_valid_mask
//   rsp      rsp_valid/rsp_ready    rsp_median_value, rsp_kept_count
//   csr      csr_valid/csr_ready    csr_index, csr_data
//
// One word per clock while rsp is not stalled; the pipe has five stages of
// moments, variance and limit, then three of keep, rank and select.
// Every stage holds its own valid bit, so a stalled rsp only holds the
// stages that are full; empty stages keep taking words.
// Synchronous reset empties the pipe and loads clip_k = 2, min count = 3.
// csr_ready is always high; writes take effect on the next word accepted.
// ----------------------------------------------------------------------------
module sigma_clipped_median_stack_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [15:0]                      req_sample_0,
   input  logic [15:0]                      req_sample_1,
   input  logic [15:0]                      req_sample_2,
   input  logic [15:0]                      req_sample_3,
   input  logic [15:0]                      req_sample_4,
   input  logic [15:0]                      req_sample_5,
   input  logic [15:0]                      req_sample_6,
   input  logic [15:0]                      req_sample_7,
   input  logic [7:0]                       req_valid_mask,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [15:0]                      rsp_median_value,
   output logic [3:0]                       rsp_kept_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sms_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [sms_pkg::CsrDataW-1:0]     csr_data
);
   import sms_pkg::*;

   logic [CsrDataW-1:0] clip_k_ff;
   logic [CsrDataW-1:0] clip_min_ff;
   sample_vec_type      req_vals;
   logic                mid_valid;
   logic                mid_ready;
   stat_type            mid_stat;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_k_ff   <= ClipKReset;
         clip_min_ff <= ClipMinCountReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrClipK:        clip_k_ff   <= csr_data;
            CsrClipMinCount: clip_min_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // gather the sample lanes
   assign req_vals[0] = req_sample_0;
   assign req_vals[1] = req_sample_1;
   assign req_vals[2] = req_sample_2;
   assign req_vals[3] = req_sample_3;
   assign req_vals[4] = req_sample_4;
   assign req_vals[5] = req_sample_5;
   assign req_vals[6] = req_sample_6;
   assign req_vals[7] = req_sample_7;

   sms_stats u_stats (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_vals        (req_vals),
      .in_mask        (req_valid_mask),
      .clip_k         (clip_k_ff),
      .clip_min_count (clip_min_ff),
      .out_valid      (mid_valid),
      .out_ready      (mid_ready),
      .out_stat       (mid_stat)
   );

   sms_select u_select (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_stat    (mid_stat),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_median (rsp_median_value),
      .out_count  (rsp_kept_count)
   );

endmodule

[verif/sigma_clipped_median_stack_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigma_clipped_median_stack_top_tb
// Self-checking bench for the sigma-clipped median stack. Words go in through
// a valid/ready channel with random gaps. An internal model of the clipping
// rule and upper-median select predicts each result, and the results are
// compared in order. The clip registers are rewritten between phases, the
// extremes among the settings.
// ----------------------------------------------------------------------------
module sigma_clipped_median_stack_top_tb;
   import sms_pkg::*;

   // one input word: eight samples and a presence mask
   typedef struct {
      logic [15:0] smp [8];
      logic [7:0]  mask;
      logic        known;   // expected result typed in
      logic [15:0] k_med;
      logic [3:0]  k_cnt;
   } word_type;

   typedef struct {
      logic [15:0] med;
      logic [3:0]  cnt;
   } median_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [15:0] req_sample [8];
   logic [7:0]  req_valid_mask = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [15:0] rsp_median_value;
   logic [3:0]  rsp_kept_count;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_data = '0;

   int          errors = 0;
   int          idle_cycles = 0;
   bit          src_done = 0;
   bit          hold_rsp = 0;
   logic [3:0]  cur_k = ClipKReset;
   logic [3:0]  cur_min = ClipMinCountReset;
   median_type  median_q [$];

   initial for (int i = 0; i < 8; i++) req_sample[i] = '0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   sigma_clipped_median_stack_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_0(req_sample[0]), .req_sample_1(req_sample[1]),
      .req_sample_2(req_sample[2]), .req_sample_3(req_sample[3]),
      .req_sample_4(req_sample[4]), .req_sample_5(req_sample[5]),
      .req_sample_6(req_sample[6]), .req_sample_7(req_sample[7]),
      .req_valid_mask(req_valid_mask),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_median_value(rsp_median_value), .rsp_kept_count(rsp_kept_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // clipped upper median of one word under the current registers
   function automatic median_type clipped_median(word_type w);
      logic [15:0] vals [$];
      logic [15:0] kept [$];
      logic [127:0] s, q, nv, d, lim;
      median_type r;
      int n;
      s = 0;
      q = 0;
      for (int i = 0; i < 8; i++) if (w.mask[i]) vals = {vals, w.smp[i]};
      n = vals.size();
      if (n == 0) begin
         r.med = 0;
         r.cnt = 0;
         return r;
      end
      if (n > cur_min) begin
         foreach (vals[i]) begin
            s += vals[i];
            q += vals[i] * 128'(vals[i]);
         end
         lim = cur_k * cur_k * (n * q - s * s);
         foreach (vals[i]) begin
            nv = n * 128'(vals[i]);
            d = (nv >= s) ? nv - s : s - nv;
            if (d * d <= lim) kept = {kept, vals[i]};
         end
      end
      if (kept.size() == 0) kept = vals;
      kept.sort();
      r.med = kept[kept.size() / 2];
      r.cnt = 4'(kept.size());
      return r;
   endfunction

   // send one word, with a random lead gap
   task automatic send_word(word_type w);
      median_type m;
      int gap;
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < 8; i++) req_sample[i] <= w.smp[i];
      req_valid_mask <= w.mask;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      m = clipped_median(w);
      if (w.known) begin
         if (m.med !== w.k_med || m.cnt !== w.k_cnt) begin
            $display("%0t predictor disagrees with table: exp %h/%0d got %h/%0d",
                     $time, w.k_med, w.k_cnt, m.med, m.cnt);
            errors++;
         end
         m.med = w.k_med;
         m.cnt = w.k_cnt;
      end
      median_q = {median_q, m};
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (median_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // register write while the pipe is empty
   task automatic write_reg(logic [CsrIndexW-1:0] idx, logic [3:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CsrClipK) cur_k = val;
      else if (idx == CsrClipMinCount) cur_min = val;
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   function automatic word_type rand_word(int mode);
      word_type w;
      logic [15:0] base;
      w.known = 0;
      w.mask = 8'($urandom());
      base = 16'($urandom());
      for (int i = 0; i < 8; i++) begin
         case (mode)
            0: w.smp[i] = 16'($urandom());
            // tight cluster with an outlier, so clipping bites
            1: w.smp[i] = (i == 7 - (base % 8)) ? 16'($urandom())
                          : base + 16'($urandom_range(0, 15));
            2: w.smp[i] = 16'(32'($urandom_range(0, 3)) * 32'hffff / 3);
            default: w.smp[i] = base;
         endcase
      end
      return w;
   endfunction

   function automatic word_type row(logic [15:0] a, logic [15:0] b, logic [7:0] mask,
                                    logic known, logic [15:0] med, logic [3:0] cnt);
      word_type w;
      for (int i = 0; i < 8; i++) w.smp[i] = (i % 2) ? b : a;
      w.mask = mask;
      w.known = known;
      w.k_med = med;
      w.k_cnt = cnt;
      return w;
   endfunction

   // result checker, with a random wait per word and one long hold-off
   initial begin
      median_type m;
      int gap;
      @(negedge clock);
      forever begin
         gap = $urandom_range(0, 7);
         if (hold_rsp) begin
            hold_rsp = 0;
            gap = 200;
         end
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (median_q.size() == 0) begin
            $display("%0t unexpected word: got %h/%0d", $time,
                     rsp_median_value, rsp_kept_count);
            errors++;
         end else begin
            m = median_q.pop_front();
            if (rsp_median_value !== m.med) begin
               $display("%0t median: exp %h got %h", $time, m.med,
                        rsp_median_value);
               errors++;
            end
            if (rsp_kept_count !== m.cnt) begin
               $display("%0t kept count: exp %0d got %0d", $time, m.cnt,
                        rsp_kept_count);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || src_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("sigma_clipped_median_stack_top: mismatch");
         $finish;
      end
   end

   // stimulus
   initial begin
      word_type table_rows [$];
      word_type w;
      logic [3:0] k_set [5];
      logic [3:0] m_set [5];
      k_set = '{4'd1, 4'd8, 4'd0, 4'd3, 4'd15};
      m_set = '{4'd0, 4'd8, 4'd2, 4'd15, 4'd1};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed rows at reset settings
      table_rows = {table_rows, row(16'h1234, 16'h5678, 8'h00, 1, 16'h0, 4'd0)};
      table_rows = {table_rows, row(16'hffff, 16'hffff, 8'hff, 1, 16'hffff, 4'd8)};
      table_rows = {table_rows, row(16'h0000, 16'h0000, 8'hff, 1, 16'h0, 4'd8)};
      table_rows = {table_rows, row(16'h0000, 16'hffff, 8'hff, 1, 16'hffff, 4'd8)};
      table_rows = {table_rows, row(16'h0010, 16'h0020, 8'h03, 1, 16'h0020, 4'd2)};
      table_rows = {table_rows, row(16'h0000, 16'hffff, 8'h01, 1, 16'h0, 4'd1)};
      table_rows = {table_rows, row(16'h0005, 16'h0009, 8'h07, 0, 0, 0)};
      table_rows = {table_rows, row(16'h0005, 16'h0009, 8'h0f, 0, 0, 0)};
      table_rows = {table_rows, row(16'h8000, 16'h7fff, 8'haa, 0, 0, 0)};
      table_rows = {table_rows, row(16'h8000, 16'h7fff, 8'h55, 0, 0, 0)};
      w = row(16'h0064, 16'h0064, 8'hff, 0, 0, 0);
      w.smp[3] = 16'hffff;    // single far outlier is clipped
      table_rows = {table_rows, w};
      foreach (table_rows[i]) send_word(table_rows[i]);
      drain();

      // near the limit: 0,0,0,4 gives var 48, n*v-S = 12 for the 4, k=2 keeps it
      write_reg(CsrClipMinCount, 4'd0);
      w = row(16'h0, 16'h0, 8'h0f, 0, 0, 0);
      w.smp[3] = 16'd4;
      send_word(w);
      w.smp[3] = 16'd5;
      send_word(w);
      drain();
      write_reg(CsrClipK, 4'd0);
      send_word(w);             // zero threshold, nothing at mean: unclipped
      send_word(row(16'h7, 16'h7, 8'hff, 0, 0, 0));
      drain();
      write_reg(CsrIndexW'(5), 4'd9);   // ignored index
      send_word(w);
      drain();

      // random phases over register settings
      for (int p = 0; p < 5; p++) begin
         write_reg(CsrClipK, k_set[p]);
         write_reg(CsrClipMinCount, m_set[p]);
         for (int i = 0; i < 370; i++) begin
            if (p == 1 && i == 50) hold_rsp = 1;
            if (p == 2 && i == 100) drain();
            send_word(rand_word(i % 4 == 0 ? $urandom_range(2, 3)
                                           : $urandom_range(0, 1)));
         end
         drain();
      end

      src_done = 1;
      if (errors == 0)
         $display("sigma_clipped_median_stack_top: match");
      else
         $display("sigma_clipped_median_stack_top: mismatch");
      $finish;
   end

endmodule
